FILE: src/tmes_pkg.sv
// Package for the tilemap edge stream addresser: constants and codes.
`timescale 1ns / 1ps
package tmes_pkg;
  localparam int unsigned MaxTileDeltaDefault = 1;
  localparam logic [15:0] PlaneOneBase = 16'h9000;
  localparam logic [15:0] PlaneTwoBase = 16'h9800;
  localparam int unsigned ColRows = 21;
  localparam int unsigned RowColsAfter = 20;
  localparam int unsigned MapSizeW = 11;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_SEED   = 2'd1,
    OP_SINGLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH  = 3'd0,
    REG_MAP_HEIGHT = 3'd1,
    REG_LOOP_H     = 3'd2,
    REG_LOOP_V     = 3'd3,
    REG_PLANE      = 3'd4
  } reg_index_t;
endpackage

FILE: src/tilemap_edge_stream_addresser.sv
// Top level of the tilemap edge stream addresser.
// Usage:
//   s_axis_* takes one transaction per item. tuser carries op. tdata packs
//   camera_x_px, camera_y_px, tile_x, tile_y. m_axis_* gives one transaction
//   per tile write. tdata packs vram_address and map_index, tuser carries
//   empty_tile, and tlast marks the last write of an item's run. cfg_*
//   writes one register per transaction.
//   A seed, or an unused op, leaves the block ready again in the next cycle.
//   A single tile write keeps the block busy through S_TILE, S_RX, S_RY,
//   S_MUL and S_OUT. A camera update handles the deltas in S_DELTA and
//   S_CLAMP, then takes each tile through those states. Each looping
//   coordinate also goes through a restoring divider, which reduces it
//   one quotient bit a cycle (17 steps and a finishing step). The map
//   index comes from one shared 11x11 multiply. An update has at most
//   43 * MAX_TILE_DELTA tiles. s_axis_tready is low while an item is
//   worked on. When the receiver stalls, the write waits in the output
//   register, and the next tile does not start until that write is taken.
//   Reset clears the camera tile state, the registers, the state and out_v.
//   The block accepts items in the cycle after reset is released.
`timescale 1ns / 1ps
module tilemap_edge_stream_addresser
  import tmes_pkg::*;
#(
  parameter int unsigned MAX_TILE_DELTA = MaxTileDeltaDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // camera_x_px[15:0], camera_y_px[31:16], tile_x[47:32], tile_y[63:48]
  input  logic [63:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // vram_address[15:0], map_index[31:16]
  output logic [31:0] m_axis_tdata,
  // empty_tile[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  localparam int unsigned DW = $clog2(MAX_TILE_DELTA + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DELTA, S_CLAMP, S_TILE, S_RX, S_DIVX, S_RY, S_DIVY, S_MUL, S_OUT
  } state_t;

  state_t state;
  logic [10:0] map_width, map_height;
  logic loop_h, loop_v, plane_sel;
  logic signed [12:0] prev_tx, prev_ty;
  logic signed [12:0] cur_tx, cur_ty;
  logic signed [14:0] dx, dy;
  logic wrap;
  // run counters: column phase first, then row phase
  logic phase_row;
  logic [DW-1:0] line_cnt, lines_x, lines_y;
  logic [4:0] k_cnt;
  logic signed [16:0] wx, wy;
  // first row of the row phase, taken from the camera tile before the update
  logic signed [16:0] wy_row;
  logic [10:0] rx, ry;
  logic okx, oky;
  // shared restoring divider
  logic [16:0] div_num;
  logic [11:0] div_rem;
  logic [4:0] div_cnt;
  logic div_neg;
  logic [15:0] vram_q, idx_q;
  logic empty_q, last_q, out_v;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata = {idx_q, vram_q};
  assign m_axis_tuser = empty_q;
  assign m_axis_tlast = last_q;

  // abs value of a 17-bit coordinate and remainder step
  logic [16:0] abs_c;
  logic [11:0] trial;
  logic [10:0] div_m;
  logic [10:0] fix_rem;
  always_comb begin
    abs_c = (state == S_RX) ? (wx[16] ? 17'(-wx) : 17'(wx))
                            : (wy[16] ? 17'(-wy) : 17'(wy));
    div_m = (state == S_DIVX) ? map_width : map_height;
    trial = {div_rem[10:0], div_num[16]} - {1'b0, div_m};
    fix_rem = (div_neg && div_rem[10:0] != 11'd0) ? div_m - div_rem[10:0]
                                                 : div_rem[10:0];
  end

  // axis bounds check for a non-wrapping coordinate
  function automatic logic in_map(logic signed [16:0] c, logic [10:0] m);
    in_map = !c[16] && (c[15:0] < {5'd0, m});
  endfunction

  logic signed [15:0] dlim;
  assign dlim = 16'(MAX_TILE_DELTA);

  // raw tile deltas and the half and full map sizes for the seam test
  logic signed [14:0] raw_dx, raw_dy, half_w, half_h, size_w, size_h;
  assign raw_dx = 15'(cur_tx) - 15'(prev_tx);
  assign raw_dy = 15'(cur_ty) - 15'(prev_ty);
  assign half_w = $signed({5'd0, map_width[10:1]});
  assign half_h = $signed({5'd0, map_height[10:1]});
  assign size_w = $signed({4'd0, map_width});
  assign size_h = $signed({4'd0, map_height});

  logic run_end_col, run_end_row;
  assign run_end_col = (k_cnt == 5'(ColRows - 1)) && (line_cnt == lines_x - DW'(1));
  assign run_end_row = (k_cnt == 5'(RowColsAfter + 1)) && (line_cnt == lines_y - DW'(1));

  logic signed [16:0] sx, sy;
  assign sx = 17'(signed'(s_axis_tdata[47:32]));
  assign sy = 17'(signed'(s_axis_tdata[63:48]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      map_width <= '0; map_height <= '0;
      loop_h <= 1'b0; loop_v <= 1'b0; plane_sel <= 1'b0;
      prev_tx <= '0; prev_ty <= '0;
      out_v <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MAP_WIDTH:  map_width <= cfg_data;
          REG_MAP_HEIGHT: map_height <= cfg_data;
          REG_LOOP_H:     loop_h <= cfg_data[0];
          REG_LOOP_V:     loop_v <= cfg_data[0];
          REG_PLANE:      plane_sel <= cfg_data[0];
          default: ;
        endcase
      end
      // output register: loaded in S_OUT, cleared when taken
      if (state == S_OUT && (!out_v || m_axis_tready)) out_v <= 1'b1;
      else if (out_v && m_axis_tready) out_v <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          cur_tx <= 13'(signed'(s_axis_tdata[15:0]) >>> 3);
          cur_ty <= 13'(signed'(s_axis_tdata[31:16]) >>> 3);
          unique case (op_t'(s_axis_tuser))
            OP_SEED: begin
              prev_tx <= 13'(signed'(s_axis_tdata[15:0]) >>> 3);
              prev_ty <= 13'(signed'(s_axis_tdata[31:16]) >>> 3);
            end
            OP_SINGLE: begin
              wx <= sx; wy <= sy; wrap <= 1'b0;
              state <= S_TILE;
            end
            OP_UPDATE: state <= S_DELTA;
            default: ;
          endcase
        end
        S_DELTA: begin
          // raw delta with one shortest-path correction
          if (loop_h && map_width != 0 && raw_dx > half_w) dx <= raw_dx - size_w;
          else if (loop_h && map_width != 0 && raw_dx < -half_w) dx <= raw_dx + size_w;
          else dx <= raw_dx;
          if (loop_v && map_height != 0 && raw_dy > half_h) dy <= raw_dy - size_h;
          else if (loop_v && map_height != 0 && raw_dy < -half_h) dy <= raw_dy + size_h;
          else dy <= raw_dy;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          lines_x <= (dx > 15'(dlim) || dx < -15'(dlim)) ? DW'(MAX_TILE_DELTA)
                     : DW'(dx[14] ? -dx : dx);
          lines_y <= (dy > 15'(dlim) || dy < -15'(dlim)) ? DW'(MAX_TILE_DELTA)
                     : DW'(dy[14] ? -dy : dy);
          prev_tx <= cur_tx; prev_ty <= cur_ty;
          line_cnt <= '0; k_cnt <= '0; wrap <= 1'b1;
          wy_row <= dy[14] ? 17'(prev_ty) - 17'sd2 : 17'(prev_ty) + 17'sd20;
          phase_row <= (dx == 0);
          if (dx == 0) begin
            wx <= 17'(cur_tx) - 17'sd1;
            wy <= dy[14] ? 17'(prev_ty) - 17'sd2 : 17'(prev_ty) + 17'sd20;
          end else begin
            wx <= dx[14] ? 17'(prev_tx) - 17'sd2 : 17'(prev_tx) + 17'sd21;
            wy <= 17'(cur_ty) - 17'sd1;
          end
          state <= (dx == 0 && dy == 0) ? S_IDLE : S_TILE;
        end
        // start a tile only once the output register is free
        S_TILE: if (!out_v || m_axis_tready) begin
          last_q <= wrap ? (phase_row ? run_end_row : (run_end_col && dy == 0)) : 1'b1;
          state <= S_RX;
        end
        S_RX: begin
          if (wrap && loop_h && map_width != 0) begin
            div_num <= abs_c; div_neg <= wx[16]; div_rem <= '0; div_cnt <= '0;
            okx <= 1'b1; state <= S_DIVX;
          end else begin
            okx <= in_map(wx, map_width); rx <= wx[10:0]; state <= S_RY;
          end
        end
        S_DIVX: begin
          div_num <= div_num << 1;
          div_rem <= trial[11] ? {div_rem[10:0], div_num[16]} : trial;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd17) begin
            rx <= fix_rem; state <= S_RY;
          end
        end
        S_RY: begin
          if (wrap && loop_v && map_height != 0) begin
            div_num <= abs_c; div_neg <= wy[16]; div_rem <= '0; div_cnt <= '0;
            oky <= 1'b1; state <= S_DIVY;
          end else begin
            oky <= in_map(wy, map_height); ry <= wy[10:0]; state <= S_MUL;
          end
        end
        S_DIVY: begin
          div_num <= div_num << 1;
          div_rem <= trial[11] ? {div_rem[10:0], div_num[16]} : trial;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd17) begin
            ry <= fix_rem; state <= S_MUL;
          end
        end
        S_MUL: begin
          idx_q <= (okx && oky) ? 16'(22'(ry) * 22'(map_width) + 22'(rx)) : '0;
          empty_q <= !(okx && oky);
          vram_q <= (plane_sel ? PlaneOneBase : PlaneTwoBase)
                    + {5'd0, wy[4:0], wx[4:0], 1'b0};
          state <= S_OUT;
        end
        S_OUT: if (!out_v || m_axis_tready) begin
          if (!wrap || last_q) state <= S_IDLE;
          else begin
            state <= S_TILE;
            if (!phase_row) begin
              if (k_cnt == 5'(ColRows - 1)) begin
                k_cnt <= '0;
                if (line_cnt == lines_x - DW'(1)) begin
                  phase_row <= 1'b1; line_cnt <= '0;
                  wx <= 17'(cur_tx) - 17'sd1;
                  wy <= wy_row;
                end else begin
                  line_cnt <= line_cnt + DW'(1);
                  wx <= dx[14] ? wx - 17'sd1 : wx + 17'sd1;
                  wy <= 17'(cur_ty) - 17'sd1;
                end
              end else begin
                k_cnt <= k_cnt + 5'd1; wy <= wy + 17'sd1;
              end
            end else begin
              if (k_cnt == 5'(RowColsAfter + 1)) begin
                k_cnt <= '0; line_cnt <= line_cnt + DW'(1);
                wx <= 17'(cur_tx) - 17'sd1;
                wy <= dy[14] ? wy - 17'sd1 : wy + 17'sd1;
              end else begin
                k_cnt <= k_cnt + 5'd1; wx <= wx + 17'sd1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an empty write always carries a zero index
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[31:16] == 16'd0))
    else $error("empty write with nonzero index");
  // no new item is taken while a run is in progress
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready)
    else $error("ready while busy");
  // a pending write holds while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("stalled write changed");
endmodule

FILE: dv/tilemap_edge_stream_addresser_tb.sv
// Self-checking testbench for the tilemap edge stream addresser.
`timescale 1ns / 1ps
module tilemap_edge_stream_addresser_tb;
  import tmes_pkg::*;

  localparam int HoldCycles = 400;
  localparam int DrainCycles = 120;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic [15:0] vram;
    logic [15:0] index;
    logic        empty;
    logic        last;
  } tile_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  tilemap_edge_stream_addresser dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's registers and camera state
  int unsigned map_w, map_h;
  bit          wrap_h, wrap_v, plane_one;
  int          cam_tile_x, cam_tile_y;

  // Pending items: op[1:0], camera_x_px[17:2], camera_y_px[33:18],
  // tile_x[49:34], tile_y[65:50]
  logic [65:0] item_q[$];
  tile_write_t write_q[$];
  int          mismatches = 0;
  int          writes_seen = 0;
  int          items_taken = 0;
  bit          quiet = 1'b0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  int          idle_cycles = 0;

  function automatic int px_tile(logic [15:0] v);
    return int'($signed(v)) >>> 3;
  endfunction

  function automatic int shortest_delta(int d, int unsigned size, bit wrap);
    int m;
    m = int'(size);
    if (wrap && m > 0) begin
      if (d > m / 2) d -= m;
      else if (d < -(m / 2)) d += m;
    end
    if (d > int'(MaxTileDeltaDefault)) d = MaxTileDeltaDefault;
    if (d < -int'(MaxTileDeltaDefault)) d = -int'(MaxTileDeltaDefault);
    return d;
  endfunction

  // Reduce one axis; returns 0 when the coordinate is off the map
  function automatic bit axis_ok(inout int c, input int unsigned size, input bit wrap);
    int m;
    m = int'(size);
    if (wrap && m > 0) begin
      c = c % m;
      if (c < 0) c += m;
      return 1'b1;
    end
    return c >= 0 && c < m;
  endfunction

  function automatic tile_write_t tile_write(int wx, int wy, bit wrap, bit last);
    tile_write_t w;
    int x, y;
    bit ok;
    logic [31:0] prod;
    x = wx;
    y = wy;
    ok = axis_ok(x, map_w, wrap && wrap_h);
    if (ok) ok = axis_ok(y, map_h, wrap && wrap_v);
    w.vram = (plane_one ? PlaneOneBase : PlaneTwoBase)
             + 16'(2 * ((wy & 31) * 32 + (wx & 31)));
    prod = 32'(y) * 32'(map_w) + 32'(x);
    w.index = ok ? prod[15:0] : 16'h0;
    w.empty = !ok;
    w.last = last;
    return w;
  endfunction

  // Expected tile writes for one accepted item
  task automatic predict_writes(logic [65:0] d);
    op_t op;
    int tx, ty, dx, dy, total, n, i, k, wx, wy;
    op = op_t'(d[1:0]);
    tx = px_tile(d[17:2]);
    ty = px_tile(d[33:18]);
    case (op)
      OP_SEED: begin
        cam_tile_x = tx;
        cam_tile_y = ty;
      end
      OP_SINGLE: begin
        write_q.push_back(tile_write(int'($signed(d[49:34])), int'($signed(d[65:50])),
                                     1'b0, 1'b1));
      end
      OP_UPDATE: begin
        dx = shortest_delta(tx - cam_tile_x, map_w, wrap_h);
        dy = shortest_delta(ty - cam_tile_y, map_h, wrap_v);
        total = (dx < 0 ? -dx : dx) * int'(ColRows)
              + (dy < 0 ? -dy : dy) * int'(RowColsAfter + 2);
        n = 0;
        for (i = 0; i < (dx < 0 ? -dx : dx); i++) begin
          wx = dx > 0 ? cam_tile_x + 21 + i : cam_tile_x - 2 - i;
          for (k = 0; k < int'(ColRows); k++) begin
            n++;
            write_q.push_back(tile_write(wx, ty - 1 + k, 1'b1, n == total));
          end
        end
        for (i = 0; i < (dy < 0 ? -dy : dy); i++) begin
          wy = dy > 0 ? cam_tile_y + 20 + i : cam_tile_y - 2 - i;
          for (k = tx - 1; k <= tx + int'(RowColsAfter); k++) begin
            n++;
            write_q.push_back(tile_write(k, wy, 1'b1, n == total));
          end
        end
        cam_tile_x = tx;
        cam_tile_y = ty;
      end
      default: ;
    endcase
  endtask

  // Input and output monitor, sampled at the rising edge
  always @(posedge clk) begin
    tile_write_t want;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      in_taken = 1'b1;
      items_taken++;
      predict_writes({s_axis_tdata, s_axis_tuser});
      void'(item_q.pop_front());
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      out_taken = 1'b1;
      writes_seen++;
      if (write_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected write: vram=%h index=%h empty=%b last=%b",
                   m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser, m_axis_tlast);
      end else begin
        want = write_q.pop_front();
        if (m_axis_tdata[15:0] !== want.vram || m_axis_tdata[31:16] !== want.index ||
            m_axis_tuser !== want.empty || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("write mismatch: exp vram=%h index=%h empty=%b last=%b, got %h %h %b %b",
                     want.vram, want.index, want.empty, want.last, m_axis_tdata[15:0],
                     m_axis_tdata[31:16], m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  // Item driver with random gaps
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst && (in_taken || !s_axis_tvalid)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (item_q.size() > 0 && (quiet || $urandom_range(0, 5) != 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= item_q[0][1:0];
        s_axis_tdata <= item_q[0][65:2];
      end else begin
        if (!quiet) send_gap <= $urandom_range(1, 11);
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Write receiver: random stalls, plus one long hold-off
  int recv_gap = 0;
  int hold_left = 0;
  bit held = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!held && writes_seen >= 60) begin
        held <= 1'b1;
        hold_left <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(1, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (in_taken || out_taken || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: %0d writes still expected", write_q.size());
      $display("tilemap_edge_stream_addresser_tb: errors");
      $finish;
    end
  end

  function automatic logic [65:0] pack_item(op_t op, int cx, int cy, int tx, int ty);
    return {16'(ty), 16'(tx), 16'(cy), 16'(cx), op};
  endfunction

  task automatic write_reg(reg_index_t idx, int unsigned value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = 11'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAP_WIDTH:  map_w = value;
      REG_MAP_HEIGHT: map_h = value;
      REG_LOOP_H:     wrap_h = value[0];
      REG_LOOP_V:     wrap_v = value[0];
      default:        plane_one = value[0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_map(int unsigned w, int unsigned h, bit lh, bit lv, bit ps);
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    write_reg(REG_LOOP_H, lh);
    write_reg(REG_LOOP_V, lv);
    write_reg(REG_PLANE, ps);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (item_q.size() != 0 || s_axis_tvalid || write_q.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Camera walk: mostly small scrolls, some seam wraps, single writes and noise
  task automatic queue_walk(int count);
    int cx, cy, r, i;
    cx = $urandom_range(0, 2000) - 1000;
    cy = $urandom_range(0, 2000) - 1000;
    item_q.push_back(pack_item(OP_SEED, cx, cy, 0, 0));
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        cx += $urandom_range(0, 24) - 12;
        cy += $urandom_range(0, 24) - 12;
        item_q.push_back(pack_item(OP_UPDATE, cx, cy, 0, 0));
      end else if (r < 14) begin
        cx += ($urandom_range(0, 1) ? 1 : -1) * (int'(map_w) * 8 - 8);
        cy += ($urandom_range(0, 1) ? 1 : -1) * (int'(map_h) * 8 + 8);
        item_q.push_back(pack_item(OP_UPDATE, cx, cy, 0, 0));
      end else if (r < 16) begin
        item_q.push_back(pack_item(OP_SINGLE, 0, 0,
                                   $urandom_range(0, int'(map_w) + 4) - 2,
                                   $urandom_range(0, int'(map_h) + 4) - 2));
      end else begin
        item_q.push_back(66'({$urandom, $urandom, $urandom}));
        cx = px_tile(item_q[$][17:2]) * 8;
        cy = px_tile(item_q[$][33:18]) * 8;
      end
    end
  endtask

  initial begin
    map_w = 0; map_h = 0; wrap_h = 0; wrap_v = 0; plane_one = 0;
    cam_tile_x = 0; cam_tile_y = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: each op, both scroll directions, extremes, clamping
    set_map(64, 32, 0, 0, 1);
    item_q.push_back(pack_item(OP_SEED, 0, 0, 0, 0));
    item_q.push_back(pack_item(OP_UPDATE, 3, 5, 0, 0));
    item_q.push_back(pack_item(OP_UPDATE, 8, 0, 0, 0));
    item_q.push_back(pack_item(OP_UPDATE, 0, 0, 0, 0));
    item_q.push_back(pack_item(OP_UPDATE, 0, 8, 0, 0));
    item_q.push_back(pack_item(OP_UPDATE, 0, 0, 0, 0));
    item_q.push_back(pack_item(OP_UPDATE, 9, 9, 0, 0));
    item_q.push_back(pack_item(OP_UPDATE, 32767, -32768, 0, 0));
    item_q.push_back(pack_item(OP_SEED, -32768, -32768, 0, 0));
    item_q.push_back(pack_item(OP_UPDATE, 32767, 32767, 0, 0));
    item_q.push_back(pack_item(OP_SINGLE, 0, 0, -32768, -32768));
    item_q.push_back(pack_item(OP_SINGLE, 0, 0, 32767, 32767));
    item_q.push_back(pack_item(OP_SINGLE, 0, 0, 0, 0));
    item_q.push_back(pack_item(OP_SINGLE, 0, 0, 63, 31));
    item_q.push_back(pack_item(OP_SINGLE, 0, 0, 64, 0));
    item_q.push_back(pack_item(OP_SINGLE, 0, 0, -1, 5));
    item_q.push_back(pack_item(OP_NONE, 4000, 4000, 7, 7));
    item_q.push_back(pack_item(OP_UPDATE, 32767, 32767, 0, 0));
    wait_idle();

    // Looping 1024 x 1024 map: seam crossing takes the short way round
    set_map(1024, 1024, 1, 1, 0);
    item_q.push_back(pack_item(OP_SEED, 0, 0, 0, 0));
    item_q.push_back(pack_item(OP_UPDATE, 1023 * 8, 1023 * 8, 0, 0));
    item_q.push_back(pack_item(OP_UPDATE, 0, 0, 0, 0));
    item_q.push_back(pack_item(OP_SINGLE, 0, 0, 1024, 1023));
    queue_walk(18);
    wait_idle();

    // Looping axes with zero size behave as empty planes
    set_map(0, 0, 1, 1, 1);
    queue_walk(14);
    wait_idle();

    set_map(40, 1, 1, 0, 0);
    queue_walk(20);
    wait_idle();

    set_map(1023, 7, 0, 1, 1);
    queue_walk(20);
    wait_idle();

    // Last part: random map, no idling on either side
    set_map($urandom_range(1, 1024), $urandom_range(1, 1024),
            $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
    quiet = 1'b1;
    queue_walk(22);
    wait_idle();

    $display("covered %0d items and %0d tile writes over six map settings,", items_taken,
             writes_seen);
    $display("with stalls on both sides and one long output hold-off");
    if (mismatches == 0 && write_q.size() == 0) begin
      $display("tilemap_edge_stream_addresser_tb: clean");
    end else begin
      $display("%0d mismatches, %0d writes missing", mismatches, write_q.size());
      $display("tilemap_edge_stream_addresser_tb: errors");
    end
    $finish;
  end
endmodule
